/* hw/rtl/agsr_pkg.sv */
`default_nettype none

package agsr_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int COST_BITS   = 32;
    localparam int CFG_BITS    = 16;
    localparam int SYM_BITS    = 8;
    localparam int POS_BITS    = 11;
    localparam int LEN_BITS    = 11;
    localparam int COL_BITS    = $clog2(MAX_COLUMNS + 1);
    localparam int SADDR_BITS  = $clog2(MAX_COLUMNS);
    localparam int IDX_BITS    = 3;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ROW  = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_MATCH    = 3'd0,
        CFG_MISMATCH = 3'd1,
        CFG_GAP_OPEN = 3'd2,
        CFG_GAP_EXT  = 3'd3,
        CFG_BND_GAP  = 3'd4,
        CFG_USED_LEN = 3'd5,
        CFG_REVERSE  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BND_A,
        ST_BND_B,
        ST_INIT_A,
        ST_INIT_B,
        ST_COL_A,
        ST_COL_B,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [1:0]          op;
        logic [SYM_BITS-1:0] symbol;
        logic [POS_BITS-1:0] position;
        logic                first_row;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] cost_out;
        logic signed [31:0] gap_cost_out;
    } t_out_item;

    typedef struct packed {
        logic signed [CFG_BITS-1:0] match_cost;
        logic signed [CFG_BITS-1:0] mismatch_cost;
        logic signed [CFG_BITS-1:0] gap_open;
        logic signed [CFG_BITS-1:0] gap_extend;
    } t_cost_cfg;

    typedef struct packed {
        logic init;
        logic step_a;
        logic step_b;
    } t_cell_ctl;

    // Signed add of a short cost to a full-width cost, clamped to the cost range.
    function automatic logic signed [COST_BITS-1:0] sat_add(
        input logic signed [COST_BITS-1:0] a,
        input logic signed [CFG_BITS-1:0]  b
    );
        logic [COST_BITS:0] s;
        s = {a[COST_BITS-1], a} + {{(COST_BITS + 1 - CFG_BITS){b[CFG_BITS-1]}}, b};
        if (s[COST_BITS] != s[COST_BITS-1]) begin
            sat_add = s[COST_BITS] ? {1'b1, {(COST_BITS - 1){1'b0}}}
                                   : {1'b0, {(COST_BITS - 1){1'b1}}};
        end else begin
            sat_add = s[COST_BITS-1:0];
        end
    endfunction

    function automatic logic signed [COST_BITS-1:0] cost_min(
        input logic signed [COST_BITS-1:0] a,
        input logic signed [COST_BITS-1:0] b
    );
        cost_min = (a < b) ? a : b;
    endfunction

    function automatic logic signed [COST_BITS-1:0] sext_cfg(
        input logic signed [CFG_BITS-1:0] v
    );
        sext_cfg = {{(COST_BITS - CFG_BITS){v[CFG_BITS-1]}}, v};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/affine_gap_score_row_pass.sv */
// Load item: written into the symbol store on the transfer, if the position is below 1024.
// Read item: ST_READ loads the result into the output register once that register is free.
// Row item: N = min(used_length, 1024) columns, boundary pass first when first_row is set;
// each column takes two steps through the shared cell, and no new item is taken until it ends.
// Reset (synchronous, active low) restores the register defaults and clears the left gap base;
// the cost, gap and symbol stores are not cleared.
`default_nettype none

module affine_gap_score_row_pass
    import agsr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_in_item            i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_out_item                o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [CFG_BITS-1:0] i_cfg_wdata
);

    t_state r_state;
    t_state n_state;

    logic signed [CFG_BITS-1:0]  r_match;
    logic signed [CFG_BITS-1:0]  r_mismatch;
    logic signed [CFG_BITS-1:0]  r_gap_open;
    logic signed [CFG_BITS-1:0]  r_gap_ext;
    logic signed [CFG_BITS-1:0]  r_bnd_gap;
    logic [LEN_BITS-1:0]         r_used_len;
    logic                        r_rev;
    logic signed [COST_BITS-1:0] r_lgb;
    logic                        r_out_valid;

    logic [COL_BITS-1:0]         r_n;
    logic [COL_BITS-1:0]         r_col;
    logic signed [COST_BITS-1:0] r_t;
    logic [SYM_BITS-1:0]         r_row_sym;
    logic                        r_rd_ok;
    t_out_item                   r_out;

    logic                        in_acc;
    logic                        out_free;
    logic                        last_col;
    logic [COL_BITS-1:0]         n_calc;

    logic                        cc_we;
    logic [COL_BITS-1:0]         cc_waddr;
    logic signed [COST_BITS-1:0] cc_wdata;
    logic                        dd_we;
    logic signed [COST_BITS-1:0] dd_wdata;
    logic                        rd_re;
    logic [COL_BITS-1:0]         rd_col;
    logic                        sym_we;
    logic [COL_BITS-1:0]         sym_k;
    logic signed [COST_BITS-1:0] cc_rdata;
    logic signed [COST_BITS-1:0] dd_rdata;
    logic [SYM_BITS-1:0]         sym_rdata;
    logic signed [COST_BITS-1:0] cell_cc;
    logic signed [COST_BITS-1:0] cell_dd;
    t_cell_ctl                   cell_ctl;
    t_cost_cfg                   cost_cfg;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign last_col = (r_col == r_n);
    assign n_calc   = (r_used_len > LEN_BITS'(MAX_COLUMNS)) ? COL_BITS'(MAX_COLUMNS)
                                                           : COL_BITS'(r_used_len);
    assign sym_k    = r_rev ? (r_n - rd_col) : (rd_col - COL_BITS'(1));

    assign cost_cfg = '{match_cost: r_match, mismatch_cost: r_mismatch,
                        gap_open: r_gap_open, gap_extend: r_gap_ext};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.op)
                        OP_ROW: begin
                            if (!i_in_data.first_row) begin
                                n_state = ST_INIT_A;
                            end else if (n_calc == '0) begin
                                n_state = ST_INIT_A;
                            end else begin
                                n_state = ST_BND_A;
                            end
                        end
                        OP_READ: n_state = ST_READ;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_BND_A:  n_state = ST_BND_B;
            ST_BND_B:  n_state = last_col ? ST_INIT_A : ST_BND_A;
            ST_INIT_A: n_state = ST_INIT_B;
            ST_INIT_B: n_state = (r_n == '0) ? ST_IDLE : ST_COL_A;
            ST_COL_A:  n_state = ST_COL_B;
            ST_COL_B:  n_state = last_col ? ST_IDLE : ST_COL_A;
            ST_READ:   n_state = out_free ? ST_IDLE : ST_READ;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        cc_we      = 1'b0;
        dd_we      = 1'b0;
        cc_waddr   = '0;
        cc_wdata   = '0;
        dd_wdata   = '0;
        rd_re      = 1'b0;
        rd_col     = '0;
        sym_we     = 1'b0;
        cell_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                rd_col     = i_in_data.position;
                if (in_acc) begin
                    case (i_in_data.op)
                        OP_LOAD: sym_we = (i_in_data.position < POS_BITS'(MAX_COLUMNS));
                        OP_ROW:  cc_we  = i_in_data.first_row;
                        OP_READ: rd_re  = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_BND_A: ;
            ST_BND_B: begin
                cc_we    = 1'b1;
                dd_we    = 1'b1;
                cc_waddr = r_col;
                cc_wdata = r_t;
                dd_wdata = sat_add(r_t, r_gap_open);
            end
            ST_INIT_A: begin
                // The old left-column cost becomes the first diagonal.
                rd_re = 1'b1;
            end
            ST_INIT_B: begin
                cell_ctl.init = 1'b1;
                cc_we         = 1'b1;
                dd_we         = 1'b1;
                cc_wdata      = r_lgb;
                dd_wdata      = r_lgb;
                rd_re         = (r_n != '0);
                rd_col        = COL_BITS'(1);
            end
            ST_COL_A: begin
                cell_ctl.step_a = 1'b1;
            end
            ST_COL_B: begin
                cell_ctl.step_b = 1'b1;
                cc_we           = 1'b1;
                dd_we           = 1'b1;
                cc_waddr        = r_col;
                cc_wdata        = cell_cc;
                dd_wdata        = cell_dd;
                rd_re           = !last_col;
                rd_col          = r_col + COL_BITS'(1);
            end
            ST_READ: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_match     <= 16'sd0;
            r_mismatch  <= 16'sd1;
            r_gap_open  <= 16'sd2;
            r_gap_ext   <= 16'sd1;
            r_bnd_gap   <= 16'sd2;
            r_used_len  <= '0;
            r_rev       <= 1'b0;
            r_lgb       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MATCH:    r_match    <= i_cfg_wdata;
                    CFG_MISMATCH: r_mismatch <= i_cfg_wdata;
                    CFG_GAP_OPEN: r_gap_open <= i_cfg_wdata;
                    CFG_GAP_EXT:  r_gap_ext  <= i_cfg_wdata;
                    CFG_BND_GAP:  r_bnd_gap  <= i_cfg_wdata;
                    CFG_USED_LEN: r_used_len <= i_cfg_wdata[LEN_BITS-1:0];
                    CFG_REVERSE:  r_rev      <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (r_state == ST_IDLE && in_acc && i_in_data.op == OP_ROW
                    && i_in_data.first_row) begin
                r_lgb <= sext_cfg(r_bnd_gap);
            end
            if (r_state == ST_INIT_A) begin
                r_lgb <= sat_add(r_lgb, r_gap_ext);
            end
            if (r_state == ST_READ && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_row_sym <= i_in_data.symbol;
                r_n       <= n_calc;
                r_col     <= COL_BITS'(1);
                r_t       <= sext_cfg(r_gap_open);
                r_rd_ok   <= (i_in_data.position <= POS_BITS'(MAX_COLUMNS));
            end
            ST_BND_A: r_t   <= sat_add(r_t, r_gap_ext);
            ST_BND_B: r_col <= last_col ? COL_BITS'(1) : r_col + COL_BITS'(1);
            ST_COL_B: r_col <= r_col + COL_BITS'(1);
            ST_READ: begin
                if (out_free) begin
                    r_out.cost_out     <= r_rd_ok ? cc_rdata : '0;
                    r_out.gap_cost_out <= r_rd_ok ? dd_rdata : '0;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    agsr_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_COLUMNS + 1)) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (cc_we),
        .i_waddr (cc_waddr),
        .i_wdata (cc_wdata),
        .i_re    (rd_re),
        .i_raddr (rd_col),
        .o_rdata (cc_rdata)
    );

    agsr_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_COLUMNS + 1)) u_gap_ram (
        .i_clk   (i_clk),
        .i_we    (dd_we),
        .i_waddr (cc_waddr),
        .i_wdata (dd_wdata),
        .i_re    (rd_re),
        .i_raddr (rd_col),
        .o_rdata (dd_rdata)
    );

    agsr_ram #(.WIDTH(SYM_BITS), .DEPTH(MAX_COLUMNS)) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (i_in_data.position[SADDR_BITS-1:0]),
        .i_wdata (i_in_data.symbol),
        .i_re    (rd_re),
        .i_raddr (sym_k[SADDR_BITS-1:0]),
        .o_rdata (sym_rdata)
    );

    agsr_cell u_cell (
        .i_clk     (i_clk),
        .i_ctl     (cell_ctl),
        .i_cfg     (cost_cfg),
        .i_left    (r_lgb),
        .i_cc_old  (cc_rdata),
        .i_dd_old  (dd_rdata),
        .i_col_sym (sym_rdata),
        .i_row_sym (r_row_sym),
        .o_cc_new  (cell_cc),
        .o_dd_new  (cell_dd)
    );

    // The column counter stays within the columns in use during both passes.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BND_A || r_state == ST_BND_B || r_state == ST_COL_A
            || r_state == ST_COL_B) |-> (r_col != '0 && r_col <= r_n))
        else $error("column counter outside the columns in use");

    a_read_goes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.op == OP_READ) |=> (r_state == ST_READ))
        else $error("read transfer did not start a read");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_READ))
        else $error("result appeared without a read");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("input accepted while a row or read is in progress");

endmodule

`default_nettype wire

/* hw/rtl/agsr_ram.sv */
`default_nettype none

module agsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic                 i_re,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/agsr_cell.sv */
`default_nettype none

module agsr_cell
    import agsr_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire t_cell_ctl                   i_ctl,
    input  wire t_cost_cfg                   i_cfg,
    input  wire logic signed [COST_BITS-1:0] i_left,
    input  wire logic signed [COST_BITS-1:0] i_cc_old,
    input  wire logic signed [COST_BITS-1:0] i_dd_old,
    input  wire logic [SYM_BITS-1:0]         i_col_sym,
    input  wire logic [SYM_BITS-1:0]         i_row_sym,
    output logic signed [COST_BITS-1:0]      o_cc_new,
    output logic signed [COST_BITS-1:0]      o_dd_new
);

    // Running horizontal gap, running cost to the left, and the diagonal.
    logic signed [COST_BITS-1:0] r_e;
    logic signed [COST_BITS-1:0] r_c;
    logic signed [COST_BITS-1:0] r_diag;
    // Half-way results between the two steps of a column.
    logic signed [COST_BITS-1:0] r_p;
    logic signed [COST_BITS-1:0] r_q;
    logic signed [COST_BITS-1:0] r_d;

    logic signed [COST_BITS-1:0] e_new;
    logic signed [CFG_BITS-1:0]  diag_cost;

    assign diag_cost = (i_col_sym == i_row_sym) ? i_cfg.match_cost : i_cfg.mismatch_cost;
    assign e_new     = sat_add(r_p, i_cfg.gap_extend);
    assign o_dd_new  = sat_add(r_q, i_cfg.gap_extend);
    assign o_cc_new  = cost_min(cost_min(o_dd_new, e_new), r_d);

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_c    <= i_left;
            r_e    <= sat_add(i_left, i_cfg.gap_open);
            r_diag <= i_cc_old;
        end
        if (i_ctl.step_a) begin
            r_p    <= cost_min(r_e, sat_add(r_c, i_cfg.gap_open));
            r_q    <= cost_min(i_dd_old, sat_add(i_cc_old, i_cfg.gap_open));
            r_d    <= sat_add(r_diag, diag_cost);
            r_diag <= i_cc_old;
        end
        if (i_ctl.step_b) begin
            r_e <= e_new;
            r_c <= o_cc_new;
        end
    end

endmodule

`default_nettype wire
